// File: rtl/tfn_pkg.sv
`timescale 1ns / 1ps
package tfn_pkg;

    // Window width for normalized cross product magnitudes
    localparam int WINDOW_BITS = 30;
    localparam int SUMSQ_BITS  = 2 * WINDOW_BITS + 2;   // sum of three squares
    localparam int ROOT_BITS   = WINDOW_BITS + 1;

    // Per-transaction sideband that travels with every stage
    typedef struct packed {
        logic valid;
        logic last_face;
        logic degenerate;
        logic [2:0] neg;
    } tfn_ctrl_t;

endpackage

// File: rtl/tfn_sqrt_cell.sv
`timescale 1ns / 1ps
// One restoring square root step: one result bit per cell.
module tfn_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [tfn_pkg::SUMSQ_BITS-1:0] rem_in,
    input  logic [tfn_pkg::ROOT_BITS-1:0]  root_in,
    output logic [tfn_pkg::SUMSQ_BITS-1:0] rem_out,
    output logic [tfn_pkg::ROOT_BITS-1:0]  root_out
);
    localparam int SB = tfn_pkg::SUMSQ_BITS;
    localparam int RB = tfn_pkg::ROOT_BITS;
    localparam int SH = 2 * (RB - 1 - STEP);

    logic [SB+1:0] trial;
    logic [SB+1:0] rem_ext;
    logic [SB-1:0] rem_next;
    logic [RB-1:0] root_next;

    always_comb
    begin
        trial   = ({{(SB+2-RB){1'b0}}, root_in} << (SH + 2)) |
                  ({{(SB+1){1'b0}}, 1'b1} << SH);
        rem_ext = {2'b00, rem_in};
        if (rem_ext >= trial)
        begin
            rem_next  = SB'(rem_ext - trial);
            root_next = {root_in[RB-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_in;
            root_next = {root_in[RB-2:0], 1'b0};
        end
    end

    logic [SB-1:0] rem_reg;
    logic [RB-1:0] root_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// File: rtl/tfn_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step for three numerators sharing a divisor.
module tfn_div_cell #(
    parameter int QBITS = 16,
    parameter int DBITS = 31,
    parameter int NBITS = 46
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DBITS-1:0]      divisor,
    input  logic [3*NBITS-1:0]    num_in,
    input  logic [3*(DBITS+1)-1:0] rem_in,
    input  logic [3*QBITS-1:0]    quo_in,
    output logic [3*NBITS-1:0]    num_out,
    output logic [3*(DBITS+1)-1:0] rem_out,
    output logic [3*QBITS-1:0]    quo_out
);
    logic [3*NBITS-1:0]     num_next;
    logic [3*(DBITS+1)-1:0] rem_next;
    logic [3*QBITS-1:0]     quo_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [DBITS+1:0] sh;
            sh = {rem_in[i*(DBITS+1) +: DBITS+1], num_in[i*NBITS + NBITS - 1]};
            num_next[i*NBITS +: NBITS] = {num_in[i*NBITS +: NBITS-1], 1'b0};
            if (sh >= {1'b0, 1'b0, divisor})
            begin
                rem_next[i*(DBITS+1) +: DBITS+1] = (DBITS+1)'(sh - {2'b00, divisor});
                quo_next[i*QBITS +: QBITS] = {quo_in[i*QBITS +: QBITS-1], 1'b1};
            end
            else
            begin
                rem_next[i*(DBITS+1) +: DBITS+1] = sh[DBITS:0];
                quo_next[i*QBITS +: QBITS] = {quo_in[i*QBITS +: QBITS-1], 1'b0};
            end
        end
    end

    logic [3*NBITS-1:0]     num_reg;
    logic [3*(DBITS+1)-1:0] rem_reg;
    logic [3*QBITS-1:0]     quo_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end
    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule

// File: rtl/triangle_face_normal.sv
`timescale 1ns / 1ps
// Pipeline: 8 front stages (edges through sum), one sqrt cell per root bit, one divide cell
//   per numerator bit; the output register is the last of 85 stages at default parameters.
// Throughput: one triangle per cycle; the whole pipeline stalls only while out valid is
//   held against low ready.
// Reset: rst_n clears all stage valid bits; payload registers are not reset.
module triangle_face_normal #(
    parameter int COORD_BITS      = 24,
    parameter int COORD_FRAC_BITS = 8,
    parameter int NORMAL_BITS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  ax,
    input  logic signed [COORD_BITS-1:0]  ay,
    input  logic signed [COORD_BITS-1:0]  az,
    input  logic signed [COORD_BITS-1:0]  bx,
    input  logic signed [COORD_BITS-1:0]  by_coord,
    input  logic signed [COORD_BITS-1:0]  bz,
    input  logic signed [COORD_BITS-1:0]  cx,
    input  logic signed [COORD_BITS-1:0]  cy,
    input  logic signed [COORD_BITS-1:0]  cz,
    input  logic                          last_face_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [NORMAL_BITS-1:0] nx,
    output logic signed [NORMAL_BITS-1:0] ny,
    output logic signed [NORMAL_BITS-1:0] nz,
    output logic                          degenerate,
    output logic                          last_face_out
);
    // COORD_FRAC_BITS only names the input format; fraction bits cancel in the normalized result.

    localparam int W   = tfn_pkg::WINDOW_BITS;
    localparam int EB  = COORD_BITS + 1;           // edge width
    localparam int PB  = 2 * EB;                   // product width
    localparam int CB  = PB + 1;                   // cross component width
    localparam int MB  = PB;                       // magnitude width
    localparam int LB  = $clog2(MB + 1);           // bit length width
    localparam int SB  = tfn_pkg::SUMSQ_BITS;
    localparam int RB  = tfn_pkg::ROOT_BITS;
    localparam int QB  = NORMAL_BITS;              // quotient bits kept
    localparam int NB  = W + NORMAL_BITS - 2 + 1;  // numerator width (m<<(N-2) + r/2)
    localparam int NSQ = RB;                       // sqrt cells
    localparam int NDV = NB;                       // divide cells
    localparam logic [QB-1:0] ONE = QB'(1) << (NORMAL_BITS - 2);

    // Global stall: everything moves when the output register can take data.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: edges ----------------
    tfn_pkg::tfn_ctrl_t c1_reg;
    logic signed [EB-1:0] e1_reg [3];
    logic signed [EB-1:0] e2_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg[0] <= EB'(bx) - EB'(ax);
            e1_reg[1] <= EB'(by_coord) - EB'(ay);
            e1_reg[2] <= EB'(bz) - EB'(az);
            e2_reg[0] <= EB'(cx) - EB'(ax);
            e2_reg[1] <= EB'(cy) - EB'(ay);
            e2_reg[2] <= EB'(cz) - EB'(az);
        end
    end

    // ---------------- stage 2: six products ----------------
    // EB x EB signed products, sign extended to the product width.
    tfn_pkg::tfn_ctrl_t c2_reg;
    logic signed [PB-1:0] pp_reg [6];
    logic signed [EB-1:0] ma [6];
    logic signed [EB-1:0] mb [6];
    always_comb
    begin
        ma[0] = e1_reg[1]; mb[0] = e2_reg[2];
        ma[1] = e1_reg[2]; mb[1] = e2_reg[1];
        ma[2] = e1_reg[2]; mb[2] = e2_reg[0];
        ma[3] = e1_reg[0]; mb[3] = e2_reg[2];
        ma[4] = e1_reg[0]; mb[4] = e2_reg[1];
        ma[5] = e1_reg[1]; mb[5] = e2_reg[0];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
                pp_reg[i] <= PB'(ma[i]) * PB'(mb[i]);
        end
    end

    // ---------------- stage 3: cross product ----------------
    tfn_pkg::tfn_ctrl_t c3_reg;
    logic signed [CB-1:0] cr_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                cr_reg[i] <= CB'(pp_reg[2*i]) - CB'(pp_reg[2*i+1]);
        end
    end

    // ---------------- stage 4: sign and magnitude ----------------
    tfn_pkg::tfn_ctrl_t c4_reg;
    logic [MB-1:0] mag_reg [3];
    logic [2:0]    neg4;
    always_comb
        for (int i = 0; i < 3; i++)
            neg4[i] = cr_reg[i][CB-1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= cr_reg[i][CB-1] ? MB'(-cr_reg[i]) : MB'(cr_reg[i]);
        end
    end

    // ---------------- stage 5: bit length of the OR ----------------
    tfn_pkg::tfn_ctrl_t c5_reg;
    logic [MB-1:0] mag5_reg [3];
    logic [LB-1:0] len_reg;
    logic [MB-1:0] orm;
    logic [LB-1:0] len_next;
    always_comb
    begin
        orm      = mag_reg[0] | mag_reg[1] | mag_reg[2];
        len_next = '0;
        for (int b = 0; b < MB; b++)
            if (orm[b])
                len_next = LB'(b + 1);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag5_reg <= mag_reg;
            len_reg  <= len_next;
        end
    end

    // ---------------- stage 6: window shift ----------------
    tfn_pkg::tfn_ctrl_t c6_reg;
    logic [W-1:0] mw_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (len_reg <= LB'(W))
                    mw_reg[i] <= W'(mag5_reg[i] << (LB'(W) - len_reg));
                else
                    mw_reg[i] <= W'(mag5_reg[i] >> (len_reg - LB'(W)));
            end
        end
    end

    // ---------------- stage 7: squares ----------------
    tfn_pkg::tfn_ctrl_t c7_reg;
    logic [2*W-1:0] sq_reg [3];
    logic [W-1:0]   mw7_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= (2*W)'(mw_reg[i]) * (2*W)'(mw_reg[i]);
            mw7_reg <= mw_reg;
        end
    end

    // ---------------- stage 8: sum ----------------
    tfn_pkg::tfn_ctrl_t c8_reg;
    logic [SB-1:0] s_reg;
    logic [W-1:0]  mw8_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg   <= SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]);
            mw8_reg <= mw7_reg;
        end
    end

    // ---------------- square root chain ----------------
    logic [SB-1:0] sq_rem  [NSQ+1];
    logic [RB-1:0] sq_root [NSQ+1];
    assign sq_rem[0]  = s_reg;
    assign sq_root[0] = '0;
    for (genvar g = 0; g < NSQ; g++)
    begin : g_sqrt
        tfn_sqrt_cell #(.STEP(g)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq_rem[g]),
            .root_in  (sq_root[g]),
            .rem_out  (sq_rem[g+1]),
            .root_out (sq_root[g+1])
        );
    end

    // sideband delay for the sqrt chain
    tfn_pkg::tfn_ctrl_t sqc_reg [NSQ];
    logic [3*W-1:0]     sqm_reg [NSQ];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSQ; i++)
                sqc_reg[i] <= '0;
        end
        else if (adv)
        begin
            sqc_reg[0] <= c8_reg;
            for (int i = 1; i < NSQ; i++)
                sqc_reg[i] <= sqc_reg[i-1];
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqm_reg[0] <= {mw8_reg[2], mw8_reg[1], mw8_reg[0]};
            for (int i = 1; i < NSQ; i++)
                sqm_reg[i] <= sqm_reg[i-1];
        end
    end

    // ---------------- divide setup ----------------
    logic [RB-1:0] root;
    assign root = (sq_root[NSQ] == '0) ? RB'(1) : sq_root[NSQ];
    logic [3*NB-1:0]     dv_num [NDV+1];
    logic [3*(RB+1)-1:0] dv_rem [NDV+1];
    logic [3*QB-1:0]     dv_quo [NDV+1];
    logic [RB-1:0]       dv_div_reg [NDV-1];
    logic [RB-1:0]       dv_div [NDV];
    tfn_pkg::tfn_ctrl_t  dvc_reg [NDV];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dv_num[0][i*NB +: NB] = (NB'(sqm_reg[NSQ-1][i*W +: W]) << (NORMAL_BITS - 2))
                                    + NB'(root >> 1);
        dv_rem[0] = '0;
        dv_quo[0] = '0;
    end
    // divisor seen by each cell: the root travels alongside its numerators
    always_comb
    begin
        dv_div[0] = root;
        for (int i = 1; i < NDV; i++)
            dv_div[i] = dv_div_reg[i-1];
    end
    for (genvar g = 0; g < NDV; g++)
    begin : g_div
        tfn_div_cell #(.QBITS(QB), .DBITS(RB), .NBITS(NB)) u_cell (
            .clk     (clk),
            .en      (adv),
            .divisor (dv_div[g]),
            .num_in  (dv_num[g]),
            .rem_in  (dv_rem[g]),
            .quo_in  (dv_quo[g]),
            .num_out (dv_num[g+1]),
            .rem_out (dv_rem[g+1]),
            .quo_out (dv_quo[g+1])
        );
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_div_reg[0] <= root;
            for (int i = 1; i < NDV - 1; i++)
                dv_div_reg[i] <= dv_div_reg[i-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NDV; i++)
                dvc_reg[i] <= '0;
        end
        else if (adv)
        begin
            dvc_reg[0] <= sqc_reg[NSQ-1];
            for (int i = 1; i < NDV; i++)
                dvc_reg[i] <= dvc_reg[i-1];
        end
    end

    // quotient fits: result at most about 2^(N-2), so QB bits of shift register are enough
    // (only the low QB quotient bits are kept, higher ones are always zero).

    // ---------------- output register ----------------
    tfn_pkg::tfn_ctrl_t oc;
    logic [QB-1:0] q [3];
    logic [QB-1:0] qc [3];
    assign oc = dvc_reg[NDV-1];
    always_comb
        for (int i = 0; i < 3; i++)
        begin
            q[i]  = dv_quo[NDV][i*QB +: QB];
            qc[i] = (q[i] > ONE) ? ONE : q[i];
        end

    logic out_valid_reg;
    logic [NORMAL_BITS-1:0] n_reg [3];
    logic deg_reg, last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= oc.valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                n_reg[i] <= oc.degenerate ? '0 : (oc.neg[i] ? -qc[i] : qc[i]);
            deg_reg  <= oc.degenerate;
            last_reg <= oc.last_face;
        end
    end
    assign out_valid     = out_valid_reg;
    assign nx            = n_reg[0];
    assign ny            = n_reg[1];
    assign nz            = n_reg[2];
    assign degenerate    = deg_reg;
    assign last_face_out = last_reg;

    // ---------------- control pipe for stages 1..8 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0; c2_reg <= '0; c3_reg <= '0; c4_reg <= '0;
            c5_reg <= '0; c6_reg <= '0; c7_reg <= '0; c8_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= '{valid: in_valid, last_face: last_face_in,
                        degenerate: 1'b0, neg: 3'b000};
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= '{valid: c3_reg.valid, last_face: c3_reg.last_face,
                        degenerate: 1'b0, neg: neg4};
            c5_reg <= '{valid: c4_reg.valid, last_face: c4_reg.last_face,
                        degenerate: (orm == '0), neg: c4_reg.neg};
            c6_reg <= c5_reg;
            c7_reg <= c6_reg;
            c8_reg <= c7_reg;
        end
    end

    // ---------------- assertions ----------------
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (nx == '0 && ny == '0 && nz == '0))
        else $error("degenerate normal not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(last_face_out))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with empty output");
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> (nx != '0 || ny != '0 || nz != '0))
        else $error("non-degenerate normal is zero");
endmodule
